// ----- src/pvivs_pkg.sv -----
// Shared types, constants and codes of the I-V curve scan sequencer.
package pvivs_pkg;

	// Curve storage
	localparam int CURVE_POINTS = 100;
	localparam int ADDR_W = $clog2(CURVE_POINTS);
	localparam int CUR_W = $clog2(CURVE_POINTS + 1);
	localparam int RAM_W = 32;

	// Reference and step formats (Q16.8)
	localparam int REF_W = 24;
	localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};
	localparam int STEP_W = 19;
	localparam int PHASE_W = 13;

	// Step = |v - floor| * 256 / STEP_DIV by reciprocal multiply
	localparam int STEP_DIV = 100;
	localparam int STEP_SHIFT = 23;
	localparam int RECIP_W = 25;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << (STEP_SHIFT + 8)) + 64'(STEP_DIV) - 64'd1) / 64'(STEP_DIV);
	localparam logic [RECIP_W-1:0] STEP_RECIP = RECIP_W'(RECIP_FULL);
	localparam int PROD_W = 16 + RECIP_W;
	localparam int QUOT_W = PROD_W - STEP_SHIFT;

	// Item commands
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_ARM  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// Register map (index = paddr[4:2])
	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_RAMP_STEP    = 3'd0;
	localparam logic [2:0] REG_VOLT_CEILING = 3'd1;
	localparam logic [2:0] REG_VOLT_FLOOR   = 3'd2;
	localparam logic [2:0] REG_RAMP_TICKS   = 3'd3;
	localparam logic [2:0] REG_SETTLE_TICKS = 3'd4;
	localparam logic [2:0] REG_RAMP_PERIOD  = 3'd5;
	localparam logic [2:0] REG_POINT_PERIOD = 3'd6;

	// Register reset values
	localparam logic [15:0] RST_RAMP_STEP    = 16'd300;
	localparam logic [15:0] RST_VOLT_CEILING = 16'd9500;
	localparam logic [15:0] RST_VOLT_FLOOR   = 16'd2500;
	localparam logic [11:0] RST_RAMP_TICKS   = 12'd1250;
	localparam logic [11:0] RST_SETTLE_TICKS = 12'd1500;
	localparam logic [7:0]  RST_RAMP_PERIOD  = 8'd50;
	localparam logic [7:0]  RST_POINT_PERIOD = 8'd100;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] volt_sample;
		logic [15:0] curr_sample;
		logic        over_input;
		logic        scan_enable;
		logic [6:0]  read_index;
	} item_t;

	typedef struct packed {
		logic [15:0] volt_ref;
		logic        scan_done;
		logic [15:0] open_volt;
		logic [6:0]  cursor_now;
		logic [15:0] point_volt;
		logic [15:0] point_curr;
	} result_t;

	typedef struct packed {
		logic [15:0] ramp_step;
		logic [15:0] volt_ceiling;
		logic [15:0] volt_floor;
		logic [11:0] ramp_ticks;
		logic [11:0] settle_ticks;
		logic [7:0]  ramp_period;
		logic [7:0]  point_period;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic prep;
		logic arm;
		logic done_tick;
		logic ramp_cnt;
		logic ramp_add;
		logic ramp_clamp;
		logic settle_inc;
		logic start_diff;
		logic start_mul;
		logic start_div;
		logic start_set;
		logic sw_cnt;
		logic period_clr;
		logic rd_idx;
		logic rd_prev;
		logic fill_start;
		logic fill_step;
		logic put;
		logic put_clamp;
		logic res_load;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] cmd;
		logic       done;
		logic       in_ramp;
		logic       in_settle;
		logic       at_start;
		logic       enable;
		logic       over;
		logic       period_hit;
		logic       cur_ge2;
		logic       fill_last;
	} dp_stat_t;

endpackage

// ----- src/pvivs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pvivs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/pvivs_cfg.sv -----
// APB configuration registers of the I-V curve scan sequencer.
module pvivs_cfg import pvivs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	// write the addressed register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_step    <= RST_RAMP_STEP;
			cfg_q.volt_ceiling <= RST_VOLT_CEILING;
			cfg_q.volt_floor   <= RST_VOLT_FLOOR;
			cfg_q.ramp_ticks   <= RST_RAMP_TICKS;
			cfg_q.settle_ticks <= RST_SETTLE_TICKS;
			cfg_q.ramp_period  <= RST_RAMP_PERIOD;
			cfg_q.point_period <= RST_POINT_PERIOD;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RAMP_STEP:    cfg_q.ramp_step    <= pwdata[15:0];
				REG_VOLT_CEILING: cfg_q.volt_ceiling <= pwdata[15:0];
				REG_VOLT_FLOOR:   cfg_q.volt_floor   <= pwdata[15:0];
				REG_RAMP_TICKS:   cfg_q.ramp_ticks   <= pwdata[11:0];
				REG_SETTLE_TICKS: cfg_q.settle_ticks <= pwdata[11:0];
				REG_RAMP_PERIOD:  cfg_q.ramp_period  <= pwdata[7:0];
				REG_POINT_PERIOD: cfg_q.point_period <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_RAMP_STEP:    prdata = 32'(cfg_q.ramp_step);
			REG_VOLT_CEILING: prdata = 32'(cfg_q.volt_ceiling);
			REG_VOLT_FLOOR:   prdata = 32'(cfg_q.volt_floor);
			REG_RAMP_TICKS:   prdata = 32'(cfg_q.ramp_ticks);
			REG_SETTLE_TICKS: prdata = 32'(cfg_q.settle_ticks);
			REG_RAMP_PERIOD:  prdata = 32'(cfg_q.ramp_period);
			REG_POINT_PERIOD: prdata = 32'(cfg_q.point_period);
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- src/pvivs_ctrl.sv -----
// Sequencing state machine: steps one item through the datapath and owns both handshakes.
module pvivs_ctrl import pvivs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	output logic     result_valid,
	input  logic     result_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [16:0] {
		ST_IDLE        = 17'b00000000000000001,
		ST_DECODE      = 17'b00000000000000010,
		ST_CLASS       = 17'b00000000000000100,
		ST_RAMP_CNT    = 17'b00000000000001000,
		ST_RAMP_ADD    = 17'b00000000000010000,
		ST_RAMP_CLAMP  = 17'b00000000000100000,
		ST_START_DIFF  = 17'b00000000001000000,
		ST_START_MUL   = 17'b00000000010000000,
		ST_START_DIV   = 17'b00000000100000000,
		ST_START_SET   = 17'b00000001000000000,
		ST_SW_CNT      = 17'b00000010000000000,
		ST_SW_CHECK    = 17'b00000100000000000,
		ST_PT_RD       = 17'b00001000000000000,
		ST_FILL        = 17'b00010000000000000,
		ST_PT_PUT      = 17'b00100000000000000,
		ST_PT_CLAMP    = 17'b01000000000000000,
		ST_FINISH      = 17'b10000000000000000
	} state_t;

	state_t state_q, state_d;
	logic   result_valid_q, result_valid_d;
	logic   accept;
	logic   slot_free;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign slot_free  = !result_valid_q || !result_stall;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.cmd)
					CMD_TICK: begin
						cmd.prep = 1'b1;
						state_d  = ST_CLASS;
					end
					CMD_ARM: begin
						cmd.arm = 1'b1;
						state_d = ST_FINISH;
					end
					CMD_READ: begin
						cmd.rd_idx = 1'b1;
						state_d    = ST_FINISH;
					end
					default: state_d = ST_FINISH;
				endcase
			end
			ST_CLASS: begin
				if (stat.done) begin
					cmd.done_tick = 1'b1;
					state_d       = ST_FINISH;
				end else if (stat.in_ramp) begin
					state_d = ST_RAMP_CNT;
				end else if (stat.in_settle) begin
					cmd.settle_inc = 1'b1;
					state_d        = ST_FINISH;
				end else if (!stat.enable) begin
					state_d = ST_FINISH;
				end else if (stat.at_start) begin
					state_d = ST_START_DIFF;
				end else begin
					state_d = ST_SW_CNT;
				end
			end
			ST_RAMP_CNT: begin
				cmd.ramp_cnt = 1'b1;
				state_d      = ST_RAMP_ADD;
			end
			ST_RAMP_ADD: begin
				cmd.ramp_add = 1'b1;
				state_d      = ST_RAMP_CLAMP;
			end
			ST_RAMP_CLAMP: begin
				cmd.ramp_clamp = 1'b1;
				state_d        = ST_FINISH;
			end
			ST_START_DIFF: begin
				cmd.start_diff = 1'b1;
				state_d        = ST_START_MUL;
			end
			ST_START_MUL: begin
				cmd.start_mul = 1'b1;
				state_d       = ST_START_DIV;
			end
			ST_START_DIV: begin
				cmd.start_div = 1'b1;
				state_d       = ST_START_SET;
			end
			ST_START_SET: begin
				cmd.start_set = 1'b1;
				state_d       = ST_FINISH;
			end
			ST_SW_CNT: begin
				cmd.sw_cnt = 1'b1;
				state_d    = ST_SW_CHECK;
			end
			ST_SW_CHECK: begin
				if (stat.period_hit) begin
					cmd.period_clr = 1'b1;
					state_d        = stat.cur_ge2 ? ST_PT_RD : ST_PT_PUT;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_PT_RD: begin
				cmd.rd_prev    = 1'b1;
				cmd.fill_start = 1'b1;
				state_d        = stat.over ? ST_FILL : ST_PT_PUT;
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (stat.fill_last) begin
					state_d = ST_PT_PUT;
				end
			end
			ST_PT_PUT: begin
				cmd.put = 1'b1;
				state_d = ST_PT_CLAMP;
			end
			ST_PT_CLAMP: begin
				cmd.put_clamp = 1'b1;
				state_d       = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result slot: set on load, drop when the beat is taken
	always_comb begin
		result_valid_d = result_valid_q;
		if (cmd.res_load) begin
			result_valid_d = 1'b1;
		end else if (result_valid_q && !result_stall) begin
			result_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= result_valid_d;
		end
	end

	assign result_valid = result_valid_q;

`ifndef NO_ASSERTIONS
	// an accepted item always goes to decode next
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DECODE))
		else $error("accepted item did not enter decode");

	// a new result appears only out of the finish state
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	// the back-fill walk starts only right after the previous point was read
	a_fill_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && $past(state_q != ST_FILL)) |-> $past(state_q == ST_PT_RD))
		else $error("back-fill entered without reading previous point");

	// a mid-sweep point is placed only with the previous point in the read register
	a_put_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PT_PUT && stat.cur_ge2) |->
			($past(state_q == ST_PT_RD) || $past(state_q == ST_FILL)))
		else $error("sweep point placed without previous point read");
`endif

endmodule

// ----- src/pvivs_dp.sv -----
// Datapath: scan state, reference arithmetic, curve RAM and result register.
module pvivs_dp import pvivs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  item_t    item,
	input  cfg_t     cfg,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output result_t  result
);

	// scan state
	logic [REF_W-1:0]         ref_q;
	logic signed [STEP_W-1:0] step_q;
	logic [15:0]              open_q;
	logic [PHASE_W-1:0]       phase_q;
	logic [7:0]               period_q;
	logic [7:0]               rampcnt_q;
	logic [1:0]               outlier_q;
	logic [CUR_W-1:0]         cursor_q;
	logic                     done_q;
	logic                     init_q;
	logic                     up_q;
	logic                     stepped_q;

	// per-item working registers
	item_t                    item_q;
	logic [PHASE_W-1:0]       settle_end_q;
	logic signed [16:0]       diff_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     neg_q;
	logic [ADDR_W-1:0]        fill_idx_q;
	result_t                  result_q;

	// RAM ports
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [RAM_W-1:0]         ram_wdata;
	logic                     ram_re;
	logic [ADDR_W-1:0]        ram_raddr;
	logic [RAM_W-1:0]         ram_rdata;

	// combinational helpers
	logic [REF_W-1:0]          floor_q8;
	logic [REF_W-1:0]          ceil_q8;
	logic [REF_W:0]            ramp_sum;
	logic [16:0]               vs_sum;
	logic                      ramp_up;
	logic [REF_W-1:0]          ref_clamped;
	logic [PHASE_W-1:0]        ramp_end1;
	logic [PHASE_W-1:0]        settle_end;
	logic signed [REF_W+2:0]   step_ext;
	logic [REF_W-1:0]          sd_val;
	logic [REF_W-1:0]          start_val;
	logic [16:0]               mag;
	logic [QUOT_W-1:0]         quot;
	logic signed [STEP_W-1:0]  step_new;
	logic [CUR_W-1:0]          prev_idx;
	logic [CUR_W-1:0]          fill_end;
	logic                      idx_ok;
	logic                      cur_ge2;
	logic                      cur_in;
	logic [15:0]               prev_volt;
	logic                      is_outlier;
	logic [1:0]                oc_inc;
	logic                      take_prev;
	logic                      put_step;

	function automatic logic [REF_W-1:0] sat_ref(input logic signed [REF_W+2:0] x);
		logic [REF_W-1:0] r;
		if (x < 0) begin
			r = '0;
		end else if (x > $signed({3'b000, REF_MAX})) begin
			r = REF_MAX;
		end else begin
			r = x[REF_W-1:0];
		end
		return r;
	endfunction

	assign floor_q8 = {cfg.volt_floor, 8'h00};
	assign ceil_q8  = {cfg.volt_ceiling, 8'h00};

	// ramp arithmetic
	assign ramp_sum    = {1'b0, ref_q} + {1'b0, cfg.ramp_step, 8'h00};
	assign vs_sum      = {1'b0, item_q.volt_sample} + {1'b0, cfg.ramp_step};
	assign ramp_up     = ({1'b0, ref_q} < {vs_sum, 8'h00});
	assign ref_clamped = (ref_q > ceil_q8) ? ceil_q8 : ref_q;

	// settle ends no earlier than one tick past the ramp
	assign ramp_end1  = {1'b0, cfg.ramp_ticks} + PHASE_W'(1);
	assign settle_end = ({1'b0, cfg.settle_ticks} < ramp_end1) ? ramp_end1
		: {1'b0, cfg.settle_ticks};

	// step arithmetic
	assign step_ext  = {{(REF_W + 3 - STEP_W){step_q[STEP_W-1]}}, step_q};
	assign sd_val    = sat_ref($signed({3'b000, ref_q}) - step_ext);
	assign start_val = sat_ref($signed({3'b000, item_q.volt_sample, 8'h00}) - step_ext);
	assign mag       = diff_q[16] ? 17'(-diff_q) : 17'(diff_q);
	assign quot      = prod_q[PROD_W-1:STEP_SHIFT];
	assign step_new  = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

	// curve indexes
	assign prev_idx = (cursor_q >= CUR_W'(CURVE_POINTS - 1)) ? CUR_W'(CURVE_POINTS - 1)
		: cursor_q + CUR_W'(1);
	assign fill_end = (cursor_q >= CUR_W'(CURVE_POINTS)) ? CUR_W'(CURVE_POINTS - 1)
		: cursor_q;
	assign idx_ok   = ({1'b0, item_q.read_index} < 8'(CURVE_POINTS));
	assign cur_ge2  = (cursor_q >= CUR_W'(2));
	assign cur_in   = (cursor_q < CUR_W'(CURVE_POINTS));

	// outlier decision against the previous point
	assign prev_volt  = ram_rdata[RAM_W-1:16];
	assign is_outlier = (item_q.volt_sample > prev_volt);
	assign oc_inc     = outlier_q + 2'd1;
	assign take_prev  = is_outlier && (oc_inc == 2'd2);
	assign put_step   = !is_outlier || take_prev;

	// curve RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		if (cmd.start_set) begin
			ram_we    = 1'b1;
			ram_waddr = ADDR_W'(CURVE_POINTS - 1);
			ram_wdata = {item_q.volt_sample, item_q.curr_sample};
		end else if (cmd.fill_step) begin
			ram_we    = 1'b1;
			ram_waddr = fill_idx_q;
			ram_wdata = ram_rdata;
		end else if (cmd.put) begin
			ram_waddr = ADDR_W'(cursor_q);
			if (cur_ge2) begin
				ram_we    = put_step && cur_in;
				ram_wdata = take_prev ? ram_rdata : {item_q.volt_sample, item_q.curr_sample};
			end else begin
				ram_we    = 1'b1;
				ram_wdata = {item_q.volt_sample, item_q.curr_sample};
			end
		end
	end

	assign ram_re    = (cmd.rd_idx && idx_ok) || cmd.rd_prev;
	assign ram_raddr = cmd.rd_prev ? ADDR_W'(prev_idx) : ADDR_W'(item_q.read_index);

	pvivs_ram #(
		.WIDTH(RAM_W),
		.DEPTH(CURVE_POINTS)
	) u_curve_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// scan state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q     <= '0;
			step_q    <= '0;
			open_q    <= '0;
			phase_q   <= '0;
			period_q  <= '0;
			rampcnt_q <= '0;
			outlier_q <= '0;
			cursor_q  <= '0;
			done_q    <= 1'b0;
			init_q    <= 1'b1;
			up_q      <= 1'b0;
			stepped_q <= 1'b0;
		end else begin
			// load the reference from the first sample after arming
			if (cmd.prep && init_q) begin
				init_q <= 1'b0;
				ref_q  <= {item_q.volt_sample, 8'h00};
			end
			if (cmd.arm) begin
				done_q    <= 1'b0;
				phase_q   <= '0;
				period_q  <= '0;
				outlier_q <= '0;
				rampcnt_q <= '0;
				init_q    <= 1'b1;
			end
			// finished scan: park at the open-circuit voltage
			if (cmd.done_tick) begin
				ref_q     <= {open_q, 8'h00};
				phase_q   <= '0;
				period_q  <= '0;
				outlier_q <= '0;
				rampcnt_q <= '0;
			end
			// ramp: count, step, clamp
			if (cmd.ramp_cnt) begin
				phase_q <= phase_q + PHASE_W'(1);
				if (rampcnt_q >= cfg.ramp_period) begin
					rampcnt_q <= '0;
					up_q      <= ramp_up;
				end else begin
					rampcnt_q <= rampcnt_q + 8'd1;
					up_q      <= 1'b0;
				end
			end
			if (cmd.ramp_add && up_q) begin
				ref_q <= ramp_sum[REF_W] ? REF_MAX : ramp_sum[REF_W-1:0];
			end
			if (cmd.ramp_clamp) begin
				ref_q    <= ref_clamped;
				open_q   <= ref_clamped[REF_W-1:8];
				cursor_q <= CUR_W'(CURVE_POINTS);
			end
			if (cmd.settle_inc) begin
				phase_q <= phase_q + PHASE_W'(1);
			end
			// sweep start: step from the span above the floor
			if (cmd.start_div) begin
				step_q <= step_new;
			end
			if (cmd.start_set) begin
				phase_q  <= phase_q + PHASE_W'(1);
				ref_q    <= start_val;
				cursor_q <= CUR_W'(CURVE_POINTS - 2);
				period_q <= '0;
			end
			// sweep: advance the point period
			if (cmd.sw_cnt) begin
				phase_q  <= settle_end_q + PHASE_W'(2);
				period_q <= period_q + 8'd1;
			end
			if (cmd.period_clr) begin
				period_q <= '0;
			end
			// place one point
			if (cmd.put) begin
				stepped_q <= 1'b0;
				if (cur_ge2) begin
					if (put_step) begin
						outlier_q <= '0;
						ref_q     <= sd_val;
						stepped_q <= 1'b1;
						cursor_q  <= cursor_q - CUR_W'(1);
					end else begin
						outlier_q <= oc_inc;
					end
				end else if (cursor_q == CUR_W'(1)) begin
					ref_q    <= floor_q8;
					cursor_q <= '0;
				end else begin
					done_q <= 1'b1;
					ref_q  <= floor_q8;
				end
			end
			// hold the stepped reference at the floor
			if (cmd.put_clamp && stepped_q && (ref_q < floor_q8)) begin
				ref_q <= floor_q8;
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.prep) begin
			settle_end_q <= settle_end;
		end
		if (cmd.start_diff) begin
			diff_q <= $signed({1'b0, item_q.volt_sample}) - $signed({1'b0, cfg.volt_floor});
		end
		if (cmd.start_mul) begin
			prod_q <= PROD_W'(mag[15:0]) * PROD_W'(STEP_RECIP);
			neg_q  <= diff_q[16];
		end
		if (cmd.fill_start) begin
			fill_idx_q <= '0;
		end else if (cmd.fill_step) begin
			fill_idx_q <= fill_idx_q + ADDR_W'(1);
		end
		if (cmd.res_load) begin
			result_q.volt_ref   <= ref_q[REF_W-1:8];
			result_q.scan_done  <= done_q;
			result_q.open_volt  <= open_q;
			result_q.cursor_now <= 7'(cursor_q);
			if (item_q.cmd == CMD_READ && idx_ok) begin
				result_q.point_volt <= ram_rdata[RAM_W-1:16];
				result_q.point_curr <= ram_rdata[15:0];
			end else begin
				result_q.point_volt <= '0;
				result_q.point_curr <= '0;
			end
		end
	end

	// status to the controller
	assign stat.cmd        = item_q.cmd;
	assign stat.done       = done_q;
	assign stat.in_ramp    = (phase_q <= {1'b0, cfg.ramp_ticks});
	assign stat.in_settle  = (phase_q <= settle_end_q);
	assign stat.at_start   = (phase_q == settle_end_q + PHASE_W'(1));
	assign stat.enable     = item_q.scan_enable;
	assign stat.over       = item_q.over_input;
	assign stat.period_hit = (period_q >= cfg.point_period);
	assign stat.cur_ge2    = cur_ge2;
	assign stat.fill_last  = (CUR_W'(fill_idx_q) == fill_end);

	assign result = result_q;

endmodule

// ----- src/pv_iv_curve_scan_sequencer_top.sv -----
// Top level of the I-V curve scan sequencer: config, controller, datapath.
//
//   channel   direction  handshake                  beat
//   item      in         item_valid / item_stall    item_t   (one command per tick)
//   result    out        result_valid / result_stall result_t (one per item)
//   config    in         APB psel/penable/pwrite    7 registers at 4*i
//
// Each item passes decode and finish; a tick also passes class, and in between a ramp
// tick adds count, add and clamp, a sweep start diff, mul, div and set, a sweep tick
// count and check, and a recorded point a previous-point read (cursor >= 2), put and
// clamp. Under overload the back-fill walk writes one curve entry per cycle (up to 100
// entries) through the single curve RAM write port. Items are taken only in idle.
// Reset clears the scan state only; the curve RAM is not cleared and needs no pass.
// One finished result waits in the result register while the next item is taken;
// a further result holds in the controller until that beat is taken.
module pv_iv_curve_scan_sequencer_top import pvivs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t     cfg;
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	pvivs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pvivs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (dp_stat),
		.cmd          (dp_cmd)
	);

	pvivs_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.cmd    (dp_cmd),
		.stat   (dp_stat),
		.result (result)
	);

endmodule

// ----- test/pv_iv_curve_scan_sequencer_top_tb.sv -----
// Self-checking testbench for the I-V curve scan sequencer top level.
module pv_iv_curve_scan_sequencer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pvivs_pkg::*;

	// Command code with no function in the block
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int unsigned BACKLOG_HOLD = 300;
	localparam int unsigned SCAN_MAX_TICKS = 320;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	item_t              item = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	pv_iv_curve_scan_sequencer_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scan state mirror
	cfg_t        cfg;
	longint      ref_q8;
	longint      step_q8;
	logic [15:0] open_v;
	int unsigned phase;
	logic [7:0]  per_cnt;
	logic [7:0]  ramp_cnt;
	logic [1:0]  outl_cnt;
	int unsigned cur;
	bit          done_f;
	bit          init_p;
	logic [15:0] curve_v [CURVE_POINTS];
	logic [15:0] curve_c [CURVE_POINTS];
	bit          stored [CURVE_POINTS];

	result_t     sequencer_reports [$];
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned send_pct = 0;
	int unsigned recv_pct = 0;
	int unsigned hold_req = 0;
	int unsigned hold_left = 0;

	function automatic void scan_reset_model();
		cfg.ramp_step = RST_RAMP_STEP;
		cfg.volt_ceiling = RST_VOLT_CEILING;
		cfg.volt_floor = RST_VOLT_FLOOR;
		cfg.ramp_ticks = RST_RAMP_TICKS;
		cfg.settle_ticks = RST_SETTLE_TICKS;
		cfg.ramp_period = RST_RAMP_PERIOD;
		cfg.point_period = RST_POINT_PERIOD;
		ref_q8 = 0;
		step_q8 = 0;
		open_v = '0;
		phase = 0;
		per_cnt = '0;
		ramp_cnt = '0;
		outl_cnt = '0;
		cur = 0;
		done_f = 1'b0;
		init_p = 1'b1;
		for (int i = 0; i < CURVE_POINTS; i++) begin
			curve_v[i] = '0;
			curve_c[i] = '0;
			stored[i] = 1'b0;
		end
	endfunction

	function automatic longint sat_ref(longint x);
		if (x < 0)
			return 0;
		if (x > longint'(REF_MAX))
			return longint'(REF_MAX);
		return x;
	endfunction

	function automatic int unsigned settle_end_tick();
		int unsigned se;
		se = cfg.settle_ticks;
		if (se < int'(cfg.ramp_ticks) + 1)
			se = int'(cfg.ramp_ticks) + 1;
		return se;
	endfunction

	function automatic void store_point(int unsigned idx, logic [15:0] v, logic [15:0] c);
		if (idx < CURVE_POINTS) begin
			curve_v[idx] = v;
			curve_c[idx] = c;
			stored[idx] = 1'b1;
		end
	endfunction

	// Step the reference down, never below the floor
	function automatic void lower_ref();
		longint fl;
		fl = longint'(cfg.volt_floor) << 8;
		ref_q8 = sat_ref(ref_q8 - step_q8);
		if (ref_q8 < fl)
			ref_q8 = fl;
	endfunction

	function automatic void record_point(logic [15:0] v, logic [15:0] c, logic over);
		int unsigned prv;
		logic [15:0] pv;
		logic [15:0] pc;
		if (cur >= 2) begin
			prv = cur + 1;
			if (prv >= CURVE_POINTS)
				prv = CURVE_POINTS - 1;
			pv = curve_v[prv];
			pc = curve_c[prv];
			// Overload: back-fill every pending entry with the previous point
			if (over)
				for (int i = 0; i <= cur && i < CURVE_POINTS; i++)
					store_point(i, pv, pc);
			if (v > pv) begin
				outl_cnt = outl_cnt + 1;
				if (outl_cnt == 2) begin
					outl_cnt = '0;
					lower_ref();
					store_point(cur, pv, pc);
					cur--;
				end
			end else begin
				outl_cnt = '0;
				lower_ref();
				store_point(cur, v, c);
				cur--;
			end
		end else if (cur == 1) begin
			ref_q8 = longint'(cfg.volt_floor) << 8;
			store_point(1, v, c);
			cur = 0;
		end else begin
			done_f = 1'b1;
			ref_q8 = longint'(cfg.volt_floor) << 8;
			store_point(0, v, c);
		end
	endfunction

	function automatic void scan_tick(logic [15:0] v, logic [15:0] c, logic over, logic en);
		int unsigned se;
		se = settle_end_tick();
		if (init_p) begin
			init_p = 1'b0;
			ref_q8 = longint'(v) << 8;
		end
		// Finished scan: park on the open-circuit voltage
		if (done_f) begin
			ref_q8 = longint'(open_v) << 8;
			phase = 0;
			per_cnt = '0;
			outl_cnt = '0;
			ramp_cnt = '0;
			return;
		end
		if (phase <= cfg.ramp_ticks) begin
			phase++;
			if (ramp_cnt >= cfg.ramp_period) begin
				ramp_cnt = '0;
				if (ref_q8 < ((longint'(v) + longint'(cfg.ramp_step)) << 8))
					ref_q8 = sat_ref(ref_q8 + (longint'(cfg.ramp_step) << 8));
			end else begin
				ramp_cnt = ramp_cnt + 1;
			end
			if (ref_q8 > (longint'(cfg.volt_ceiling) << 8))
				ref_q8 = longint'(cfg.volt_ceiling) << 8;
			open_v = ref_q8[23:8];
			cur = CURVE_POINTS;
		end else if (phase <= se) begin
			phase++;
		end else if (!en) begin
			// hold the sweep
		end else if (phase == se + 1) begin
			phase++;
			step_q8 = ((longint'(v) - longint'(cfg.volt_floor)) * 256) / 100;
			ref_q8 = sat_ref((longint'(v) << 8) - step_q8);
			store_point(CURVE_POINTS - 1, v, c);
			cur = CURVE_POINTS - 2;
			per_cnt = '0;
		end else begin
			phase = se + 2;
			per_cnt = per_cnt + 1;
			if (per_cnt >= cfg.point_period) begin
				per_cnt = '0;
				record_point(v, c, over);
			end
		end
	endfunction

	// Advance the mirror by one beat and return the report it must produce
	function automatic result_t scan_advance(item_t it);
		result_t r;
		int unsigned ri;
		r = '0;
		case (it.cmd)
			CMD_TICK: begin
				scan_tick(it.volt_sample, it.curr_sample, it.over_input, it.scan_enable);
			end
			CMD_ARM: begin
				done_f = 1'b0;
				phase = 0;
				per_cnt = '0;
				outl_cnt = '0;
				ramp_cnt = '0;
				init_p = 1'b1;
			end
			CMD_READ: begin
				ri = it.read_index;
				if (ri < CURVE_POINTS) begin
					r.point_volt = curve_v[ri];
					r.point_curr = curve_c[ri];
				end
			end
			default: begin
			end
		endcase
		r.volt_ref = ref_q8[23:8];
		r.scan_done = done_f;
		r.open_volt = open_v;
		r.cursor_now = cur[6:0];
		return r;
	endfunction

	function automatic item_t mk_item(logic [1:0] cmd, logic [15:0] v, logic [15:0] c,
		logic over, logic en, logic [6:0] idx);
		item_t it;
		it.cmd = cmd;
		it.volt_sample = v;
		it.curr_sample = c;
		it.over_input = over;
		it.scan_enable = en;
		it.read_index = idx;
		return it;
	endfunction

	// Read only entries already written, or past the end of the curve
	function automatic logic [6:0] pick_read_index();
		int unsigned r;
		if ($urandom_range(4) != 0)
			for (int k = 0; k < 8; k++) begin
				r = $urandom_range(CURVE_POINTS - 1);
				if (stored[r])
					return r[6:0];
			end
		return 7'($urandom_range(127, CURVE_POINTS));
	endfunction

	// Shape the next beat from the scan state: high start, mostly falling sweep
	function automatic item_t make_scan_item();
		item_t it;
		int unsigned roll;
		int unsigned se;
		int unsigned prv;
		logic [15:0] pv;
		it = mk_item(CMD_TICK, 16'($urandom), 16'($urandom), 1'($urandom),
			($urandom_range(99) >= 6), 7'($urandom));
		roll = $urandom_range(99);
		se = settle_end_tick();
		if (roll < 8) begin
			it.cmd = CMD_READ;
			it.read_index = pick_read_index();
		end else if (roll == 8) begin
			it.cmd = CMD_SPARE;
		end else if (roll == 9) begin
			it.cmd = CMD_ARM;
		end else if (!done_f && phase == se + 1) begin
			it.volt_sample = 16'($urandom_range(65535, 20000));
		end else if (!done_f && phase > se + 1 && cur >= 2) begin
			prv = (cur + 1 >= CURVE_POINTS) ? CURVE_POINTS - 1 : cur + 1;
			pv = curve_v[prv];
			it.over_input = ($urandom_range(99) < 4);
			if ($urandom_range(99) < 80 || pv == 16'hFFFF)
				it.volt_sample = pv - 16'($urandom_range((pv < 400) ? pv : 400));
			else
				it.volt_sample = 16'($urandom_range(65535, int'(pv) + 1));
		end
		return it;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compare each taken report beat with the oldest one due
	always @(posedge clk) begin : report_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (sequencer_reports.size() == 0) begin
				$display("%0t ns: report with none due, expected nothing, got %p", $time, result);
				errors++;
			end else begin
				want = sequencer_reports.pop_front();
				check_field("volt_ref", want.volt_ref, result.volt_ref);
				check_field("scan_done", 16'(want.scan_done), 16'(result.scan_done));
				check_field("open_volt", want.open_volt, result.open_volt);
				check_field("cursor_now", 16'(want.cursor_now), 16'(result.cursor_now));
				check_field("point_volt", want.point_volt, result.point_volt);
				check_field("point_curr", want.point_curr, result.point_curr);
			end
		end
	end

	// Receiver stall: random, or a long counted hold when requested
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	// Offer one beat and hold it until taken; entered and left at a falling edge
	task automatic send_beat(input item_t it);
		while ($urandom_range(99) < send_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sequencer_reports.push_back(scan_advance(it));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_reports_drained();
		item_valid <= 1'b0;
		do @(negedge clk); while (sequencer_reports.size() != 0);
	endtask

	// Setup then access; psel stays up for a following write
	task automatic apb_write(input logic [2:0] idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_RAMP_STEP:    cfg.ramp_step = val;
			REG_VOLT_CEILING: cfg.volt_ceiling = val;
			REG_VOLT_FLOOR:   cfg.volt_floor = val;
			REG_RAMP_TICKS:   cfg.ramp_ticks = val[11:0];
			REG_SETTLE_TICKS: cfg.settle_ticks = val[11:0];
			REG_RAMP_PERIOD:  cfg.ramp_period = val[7:0];
			REG_POINT_PERIOD: cfg.point_period = val[7:0];
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	task automatic write_all_regs(input logic [15:0] rs, input logic [15:0] ceil_v,
		input logic [15:0] fl, input logic [11:0] rt, input logic [11:0] st,
		input logic [7:0] rp, input logic [7:0] pp);
		apb_write(REG_RAMP_STEP, rs);
		apb_write(REG_VOLT_CEILING, ceil_v);
		apb_write(REG_VOLT_FLOOR, fl);
		apb_write(REG_RAMP_TICKS, 16'(rt));
		apb_write(REG_SETTLE_TICKS, 16'(st));
		apb_write(REG_RAMP_PERIOD, 16'(rp));
		apb_write(REG_POINT_PERIOD, 16'(pp));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Field extremes, every command, holds, outliers, overload, reads, arming
	task automatic test_directed_cases();
		send_pct = 16;
		recv_pct = 66;
		// zero periods, settle not above ramp, full ramp step, floor at zero
		write_all_regs(16'hFFFF, 16'hFFFF, 16'h0000, 12'd0, 12'd0, 8'd0, 8'd0);
		send_beat(mk_item(CMD_SPARE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 7'h7F));
		send_beat(mk_item(CMD_READ, 16'h0000, 16'h0000, 1'b0, 1'b0, 7'd127));
		send_beat(mk_item(CMD_READ, 16'h0000, 16'h0000, 1'b0, 1'b0, 7'd100));
		send_beat(mk_item(CMD_TICK, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 7'd0));
		send_beat(mk_item(CMD_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 7'd0));
		send_beat(mk_item(CMD_TICK, 16'h1234, 16'h0000, 1'b0, 1'b0, 7'd0));
		send_beat(mk_item(CMD_TICK, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 7'd0));
		send_beat(mk_item(CMD_TICK, 16'hFFF0, 16'h0001, 1'b0, 1'b1, 7'd0));
		send_beat(mk_item(CMD_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, 7'd0));
		send_beat(mk_item(CMD_TICK, 16'hFFFF, 16'h5555, 1'b0, 1'b1, 7'd0));
		send_beat(mk_item(CMD_TICK, 16'hFFFF, 16'hAAAA, 1'b0, 1'b1, 7'd0));
		send_beat(mk_item(CMD_TICK, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 7'd0));
		send_beat(mk_item(CMD_READ, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 7'd99));
		send_beat(mk_item(CMD_READ, 16'h0000, 16'h0000, 1'b0, 1'b0, 7'd0));
		send_beat(mk_item(CMD_READ, 16'h0000, 16'h0000, 1'b0, 1'b0, 7'd96));
		send_beat(mk_item(CMD_ARM, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 7'h7F));
		send_beat(mk_item(CMD_TICK, 16'h0000, 16'h0000, 1'b0, 1'b1, 7'd0));
		wait_reports_drained();
		// opposite extremes of every register
		write_all_regs(16'h0000, 16'h0000, 16'hFFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF);
		send_beat(mk_item(CMD_ARM, 16'h0000, 16'h0000, 1'b0, 1'b0, 7'd0));
		send_beat(mk_item(CMD_TICK, 16'hFFFF, 16'h8000, 1'b0, 1'b1, 7'd0));
		send_beat(mk_item(CMD_TICK, 16'h0000, 16'h0001, 1'b1, 1'b1, 7'd0));
		send_beat(mk_item(CMD_READ, 16'h0000, 16'h0000, 1'b0, 1'b0, 7'd1));
		wait_reports_drained();
	endtask

	// Full scans under fresh random settings until the beat budget is spent
	task automatic test_random_scans(input int unsigned s_pct, input int unsigned r_pct,
		input int unsigned budget);
		int unsigned start_cnt;
		int unsigned scan_len;
		int unsigned after_done;
		send_pct = s_pct;
		recv_pct = r_pct;
		start_cnt = items_sent;
		while (items_sent - start_cnt < budget) begin
			wait_reports_drained();
			write_all_regs(
				($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000)),
				16'($urandom),
				($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15000)),
				12'($urandom_range(8)),
				12'($urandom_range(14)),
				8'($urandom_range(3)),
				($urandom_range(3) == 0) ? 8'($urandom_range(3, 2)) : 8'($urandom_range(1)));
			send_beat(mk_item(CMD_ARM, 16'($urandom), 16'($urandom), 1'($urandom),
				1'($urandom), 7'($urandom)));
			scan_len = 0;
			after_done = 0;
			while (scan_len < SCAN_MAX_TICKS && after_done < 4 &&
				items_sent - start_cnt < budget) begin
				send_beat(make_scan_item());
				scan_len++;
				if (done_f)
					after_done++;
			end
		end
	endtask

	// Hold the receiver off long enough to back the block up, then let it drain
	task automatic test_output_backlog();
		send_pct = 0;
		recv_pct = 0;
		hold_req = BACKLOG_HOLD;
		for (int n = 0; n < 40; n++)
			send_beat(make_scan_item());
		wait_reports_drained();
	endtask

	initial begin
		scan_reset_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_random_scans(16, 66, 360);
		test_output_backlog();
		test_random_scans(66, 16, 350);
		test_random_scans(0, 0, 350);
		wait_reports_drained();
		repeat (150) @(negedge clk);
		if (errors == 0)
			$display("pv_iv_curve_scan_sequencer_top_tb OK");
		else
			$display("pv_iv_curve_scan_sequencer_top_tb NOT OK");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("pv_iv_curve_scan_sequencer_top_tb NOT OK");
		$finish;
	end

endmodule
